// File: rtl/pmsc_pkg.sv
// Package: widths, reset values, register indexes and shared types of the PID speed controller.
package pmsc_pkg;

  localparam int INTEGRAL_WIDTH_DEF = 40;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  localparam int FREQ_W    = 24;
  localparam int GAIN_W    = 24;
  localparam int OFFSET_W  = 16;
  localparam int CMD_W     = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int ERR_W     = FREQ_W + 1;
  localparam int DIFF_W    = FREQ_W + 2;
  localparam int CHUNK_W   = 32;
  localparam int ACC_HEAD_W = 2 * GAIN_W;

  localparam logic signed [GAIN_W-1:0]   PLANT_SCALE_RST = 24'sd1444141;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RST      = 16'sd737;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_TARGET      = 3'd3,
    CFG_PLANT_SCALE = 3'd4,
    CFG_OFFSET      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic top;
  } mac_ctrl_t;

endpackage

// File: rtl/pid_motor_speed_controller_core.sv
// PID speed controller core: one measured frequency sample in, one saturated motor command out.
// Each transaction forms the error against the target frequency, updates the saturating
// integral and the derivative, then evaluates Km*(Kp*e + Ki*I + Kd*D) + offset exactly and
// rounds half away from zero to a 16-bit signed command; out_saturated flags integral or
// command clipping. One 24x33-bit multiply-accumulate unit does all four products, one
// 32-bit operand chunk per cycle, under a small sequencer that steps through the integral
// update, the P, I and D products, the operand load, the plant scale product and rounding.
// The next sample is accepted once the result is moved to the output register. The result
// sits in an output register, so a stalled result does not block the next sample unless it
// is still unclaimed when the following result is ready. The user must write configuration
// only while no transaction is pending; the block itself does not enforce this.
module pid_motor_speed_controller_core #(
  parameter int INTEGRAL_WIDTH = pmsc_pkg::INTEGRAL_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = pmsc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pmsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pmsc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [pmsc_pkg::FREQ_W-1:0]          in_measured_frequency,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pmsc_pkg::CMD_W-1:0]    out_motor_command,
  output logic                                 out_saturated
);
  import pmsc_pkg::*;

  localparam int IW    = INTEGRAL_WIDTH;
  localparam int S_W   = IW + GAIN_W;
  localparam int V_W   = IW + ACC_HEAD_W;
  localparam int SH    = 2 * GAIN_FRAC_BITS + 8;
  localparam int NE    = (ERR_W + CHUNK_W - 1) / CHUNK_W;
  localparam int NI    = (IW + CHUNK_W - 1) / CHUNK_W;
  localparam int ND    = (DIFF_W + CHUNK_W - 1) / CHUNK_W;
  localparam int NS    = (S_W + CHUNK_W - 1) / CHUNK_W;
  localparam int OP_W  = NS * CHUNK_W;
  localparam int CNT_W = $clog2(NS + 1);

  localparam logic signed [V_W-1:0] HALF    = {{(V_W-1){1'b0}}, 1'b1} << (SH - 1);
  localparam logic signed [V_W-1:0] HALF_M1 = HALF - {{(V_W-1){1'b0}}, 1'b1};
  localparam logic signed [V_W-1:0] CMD_MAX = V_W'(32767);
  localparam logic signed [V_W-1:0] CMD_MIN = -V_W'(32768);
  localparam logic signed [IW-1:0]  I_MAX   = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0]  I_MIN   = {1'b1, {(IW-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INTEG,
    ST_MUL,
    ST_ACC,
    ST_LDS,
    ST_ROUND
  } state_t;

  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D,
    TERM_S
  } term_t;

  // configuration
  logic signed [GAIN_W-1:0]   gain_p_r;
  logic signed [GAIN_W-1:0]   gain_i_r;
  logic signed [GAIN_W-1:0]   gain_d_r;
  logic [FREQ_W-1:0]          target_r;
  logic signed [GAIN_W-1:0]   plant_scale_r;
  logic signed [OFFSET_W-1:0] offset_r;

  // control
  state_t                     state_r;
  term_t                      tsel_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       first_r;
  logic                       sat_r;
  logic                       out_valid_r;
  logic signed [CMD_W-1:0]    out_cmd_r;
  logic                       out_sat_r;

  // datapath
  logic signed [ERR_W-1:0]    e_r;
  logic signed [IW-1:0]       integ_r;
  logic signed [DIFF_W-1:0]   prev_r;
  logic signed [DIFF_W-1:0]   d_r;
  logic signed [S_W-1:0]      s_r;
  logic signed [V_W-1:0]      v_r;
  logic [OP_W-1:0]            op_r;

  logic signed [ERR_W-1:0]    e_new;
  logic signed [IW:0]         isum;
  logic                       iovf;
  logic signed [IW-1:0]       integ_nxt;
  logic [OP_W-1:0]            op_e;
  logic signed [GAIN_W-1:0]   mac_gain;
  mac_ctrl_t                  mac_ctrl;
  logic signed [V_W-1:0]      acc;
  logic signed [V_W-1:0]      rsum;
  logic signed [V_W-1:0]      rq;
  logic                       cmd_hi;
  logic                       cmd_lo;
  logic signed [CMD_W-1:0]    cmd_sat;
  logic                       out_free;

  assign e_new = $signed({1'b0, target_r}) - $signed({1'b0, in_measured_frequency});

  assign isum      = (IW+1)'(integ_r) + (IW+1)'(e_r);
  assign iovf      = isum[IW] != isum[IW-1];
  assign integ_nxt = iovf ? (isum[IW] ? I_MIN : I_MAX) : isum[IW-1:0];

  // operands placed so their top chunk sits at the top of the shift register
  assign op_e = OP_W'(e_r) << (OP_W - NE * CHUNK_W);

  always_comb begin
    unique case (tsel_r)
      TERM_P:  mac_gain = gain_p_r;
      TERM_I:  mac_gain = gain_i_r;
      TERM_D:  mac_gain = gain_d_r;
      TERM_S:  mac_gain = plant_scale_r;
      default: mac_gain = plant_scale_r;
    endcase
  end

  assign mac_ctrl.en  = state_r == ST_MUL;
  assign mac_ctrl.clr = first_r;
  assign mac_ctrl.top = first_r;

  pmsc_mac #(
    .ACC_W (V_W)
  ) u_mac (
    .clk   (clk),
    .ctrl  (mac_ctrl),
    .gain  (mac_gain),
    .chunk (op_r[OP_W-1 -: CHUNK_W]),
    .acc   (acc)
  );

  // round half away from zero: bias by half, less one for negative values, then shift
  assign rsum    = v_r + (v_r[V_W-1] ? HALF_M1 : HALF);
  assign rq      = rsum >>> SH;
  assign cmd_hi  = rq > CMD_MAX;
  assign cmd_lo  = rq < CMD_MIN;
  assign cmd_sat = cmd_hi ? CMD_W'(CMD_MAX) : (cmd_lo ? CMD_W'(CMD_MIN) : CMD_W'(rq));
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r      <= '0;
      gain_i_r      <= '0;
      gain_d_r      <= '0;
      target_r      <= '0;
      plant_scale_r <= PLANT_SCALE_RST;
      offset_r      <= OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GAIN_P:      gain_p_r      <= $signed(cfg_data);
        CFG_GAIN_I:      gain_i_r      <= $signed(cfg_data);
        CFG_GAIN_D:      gain_d_r      <= $signed(cfg_data);
        CFG_TARGET:      target_r      <= cfg_data;
        CFG_PLANT_SCALE: plant_scale_r <= $signed(cfg_data);
        CFG_OFFSET:      offset_r      <= $signed(cfg_data[OFFSET_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r  <= '0;
    end else if (state_r == ST_INTEG) begin
      integ_r <= integ_nxt;
      prev_r  <= DIFF_W'(e_r);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        e_r <= e_new;
      end
      ST_INTEG: begin
        d_r  <= DIFF_W'(e_r) - prev_r;
        s_r  <= '0;
        op_r <= op_e;
      end
      ST_MUL: begin
        op_r <= op_r << CHUNK_W;
      end
      ST_ACC: begin
        unique case (tsel_r)
          TERM_P: begin
            s_r  <= s_r + S_W'(acc);
            op_r <= OP_W'(integ_r) << (OP_W - NI * CHUNK_W);
          end
          TERM_I: begin
            s_r  <= s_r + S_W'(acc);
            op_r <= OP_W'(d_r) << (OP_W - ND * CHUNK_W);
          end
          TERM_D: begin
            s_r  <= s_r + S_W'(acc);
          end
          TERM_S: begin
            v_r  <= acc + (V_W'(offset_r) <<< SH);
          end
          default: ;
        endcase
      end
      ST_LDS: begin
        op_r <= OP_W'(s_r) << (OP_W - NS * CHUNK_W);
      end
      ST_ROUND: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tsel_r      <= TERM_P;
      cnt_r       <= '0;
      first_r     <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_cmd_r   <= '0;
      out_sat_r   <= 1'b0;
    end else begin
      if (state_r == ST_ROUND && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_INTEG;
          end
        end
        ST_INTEG: begin
          sat_r   <= iovf;
          tsel_r  <= TERM_P;
          cnt_r   <= CNT_W'(NE);
          first_r <= 1'b1;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          first_r <= 1'b0;
          cnt_r   <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          unique case (tsel_r)
            TERM_P: begin
              tsel_r  <= TERM_I;
              cnt_r   <= CNT_W'(NI);
              first_r <= 1'b1;
              state_r <= ST_MUL;
            end
            TERM_I: begin
              tsel_r  <= TERM_D;
              cnt_r   <= CNT_W'(ND);
              first_r <= 1'b1;
              state_r <= ST_MUL;
            end
            TERM_D:  state_r <= ST_LDS;
            TERM_S:  state_r <= ST_ROUND;
            default: state_r <= ST_ROUND;
          endcase
        end
        ST_LDS: begin
          tsel_r  <= TERM_S;
          cnt_r   <= CNT_W'(NS);
          first_r <= 1'b1;
          state_r <= ST_MUL;
        end
        ST_ROUND: begin
          if (out_free) begin
            out_cmd_r   <= cmd_sat;
            out_sat_r   <= sat_r | cmd_hi | cmd_lo;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall          = state_r != ST_IDLE;
  assign out_valid         = out_valid_r;
  assign out_motor_command = out_cmd_r;
  assign out_saturated     = out_sat_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_INTEG))
    else $error("accepted transaction did not start the integral update");

  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (cnt_r != '0))
    else $error("multiply step with an empty chunk count");

  a_scale_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LDS) |=> (state_r == ST_MUL && tsel_r == TERM_S && first_r))
    else $error("plant scale product did not follow the operand load");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && out_valid_r && out_stall)
      |=> (out_valid_r && $stable(out_cmd_r) && state_r == ST_ROUND))
    else $error("pending result overwritten");

endmodule

// File: rtl/pmsc_mac.sv
// Shared signed multiply-accumulate unit: gain times one operand chunk, Horner accumulation.
module pmsc_mac #(
  parameter int ACC_W = pmsc_pkg::INTEGRAL_WIDTH_DEF + pmsc_pkg::ACC_HEAD_W
) (
  input  logic                              clk,
  input  pmsc_pkg::mac_ctrl_t               ctrl,
  input  logic signed [pmsc_pkg::GAIN_W-1:0] gain,
  input  logic [pmsc_pkg::CHUNK_W-1:0]      chunk,
  output logic signed [ACC_W-1:0]           acc
);
  import pmsc_pkg::*;

  logic signed [CHUNK_W:0]        opnd;
  logic signed [GAIN_W+CHUNK_W:0] prod;
  logic signed [ACC_W-1:0]        acc_base;
  logic signed [ACC_W-1:0]        acc_nxt;
  logic signed [ACC_W-1:0]        acc_r;

  // top chunk carries the operand sign, lower chunks are unsigned
  assign opnd     = {ctrl.top & chunk[CHUNK_W-1], chunk};
  assign prod     = gain * opnd;
  assign acc_base = ctrl.clr ? '0 : (acc_r <<< CHUNK_W);
  assign acc_nxt  = acc_base + ACC_W'(prod);
  assign acc      = acc_r;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule
